### rtl/ttoi_pkg.sv
// Shared types and constants for the text-to-integer parser.
// Used by every module under rtl; depends on nothing.
`timescale 1ns / 1ps

package ttoi_pkg;

  // Width of the saturating byte position and of the consumed count.
  localparam int CountWidth = 16;
  localparam logic [CountWidth-1:0] CountMax = '1;

  // Radix handling.
  localparam int BaseWidth = 6;
  localparam logic [BaseWidth-1:0] MaxBase  = 6'd36;
  localparam logic [BaseWidth-1:0] NotDigit = 6'd36;
  localparam logic [BaseWidth-1:0] BaseOct  = 6'd8;
  localparam logic [BaseWidth-1:0] BaseDec  = 6'd10;
  localparam logic [BaseWidth-1:0] BaseHex  = 6'd16;
  localparam logic [BaseWidth-1:0] BaseAuto = 6'd0;
  localparam logic [BaseWidth-1:0] BaseOne  = 6'd1;

  // Configuration register indexes.
  localparam logic CfgNumberBase = 1'b0;
  localparam logic CfgSignedMode = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_DIGITS = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_BAD_BASE  = 2'd3
  } status_t;

  // Decoded view of one text byte.
  typedef struct packed {
    logic [BaseWidth-1:0] digit;
    logic                 is_space;
    logic                 is_minus;
    logic                 is_plus;
    logic                 is_zero;
    logic                 is_x;
  } char_info_t;

  // One finished result word.
  typedef struct packed {
    logic [63:0]           value;
    logic [CountWidth-1:0] count;
    status_t               status;
  } result_t;

endpackage

### rtl/ttoi_classify.sv
// Character decoder: digit value and the special characters of the grammar.
// Depends on ttoi_pkg.
`timescale 1ns / 1ps

module ttoi_classify
  import ttoi_pkg::*;
(
  input  logic [7:0] text_byte,
  output char_info_t info
);

  logic [BaseWidth-1:0] digit;

  // Digit value for 0-9, A-Z and a-z; anything else reads as not a digit.
  always_comb begin
    if (text_byte >= 8'h30 && text_byte <= 8'h39) begin
      digit = BaseWidth'(text_byte - 8'h30);
    end else if (text_byte >= 8'h41 && text_byte <= 8'h5A) begin
      digit = BaseWidth'(text_byte - 8'd55);
    end else if (text_byte >= 8'h61 && text_byte <= 8'h7A) begin
      digit = BaseWidth'(text_byte - 8'd87);
    end else begin
      digit = NotDigit;
    end
  end

  assign info.digit = digit;

  // Whitespace is space, tab, line feed, vertical tab, form feed and return.
  assign info.is_space = (text_byte == 8'h20) || (text_byte >= 8'h09 && text_byte <= 8'h0D);
  assign info.is_minus = (text_byte == 8'h2D);
  assign info.is_plus  = (text_byte == 8'h2B);
  assign info.is_zero  = (text_byte == 8'h30);
  assign info.is_x     = (text_byte == 8'h78) || (text_byte == 8'h58);

endmodule

### rtl/ttoi_core.sv
// Parse state machine with the multiply-add accumulator and result selection.
// Depends on ttoi_pkg; takes decoded bytes from ttoi_classify.
`timescale 1ns / 1ps

module ttoi_core
  import ttoi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step_en,
  input  logic                 first,
  input  char_info_t           info,
  input  logic [BaseWidth-1:0] number_base,
  input  logic                 signed_mode,
  output logic                 res_valid,
  output result_t              res
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_SPACE, PH_SIGNED, PH_ZERO, PH_PREFIX, PH_DIGITS, PH_DONE
  } phase_t;

  phase_t                phase, phase_next;
  logic [63:0]           acc, acc_next;
  logic                  neg, neg_next;
  logic [BaseWidth-1:0]  base, base_next;
  logic                  ovf, ovf_next;
  logic                  dseen, dseen_next;
  logic [CountWidth-1:0] pos, pos_next;

  // State as seen by this byte: a first byte restarts the parse.
  phase_t                cur_phase;
  logic [63:0]           cur_acc;
  logic                  cur_neg;
  logic [BaseWidth-1:0]  cur_base;
  logic                  cur_ovf;
  logic                  cur_dseen;
  logic [CountWidth-1:0] cur_pos;

  logic                 bad_base;
  logic                 begin_num;
  logic                 zero_start;
  logic                 digit_path;
  logic                 prefix_end;
  logic                 digit_take;
  logic                 emit;
  logic                 active;
  logic [BaseWidth-1:0] base_eff;
  logic [63:0]          lim;
  logic [69:0]          prod;
  logic [70:0]          sum;
  logic                 over;

  assign cur_phase = first ? PH_SPACE : phase;
  assign cur_acc   = first ? '0 : acc;
  assign cur_neg   = first ? 1'b0 : neg;
  assign cur_base  = first ? number_base : base;
  assign cur_ovf   = first ? 1'b0 : ovf;
  assign cur_dseen = first ? 1'b0 : dseen;
  assign cur_pos   = first ? '0 : pos;

  assign bad_base = first && (number_base == BaseOne || number_base > MaxBase);

  // Path selection for this byte.
  always_comb begin
    begin_num  = 1'b0;
    digit_path = 1'b0;
    prefix_end = 1'b0;
    base_eff   = cur_base;
    active     = 1'b0;
    if (!bad_base) begin
      unique case (cur_phase)
        PH_SPACE: begin
          active    = 1'b1;
          begin_num = !info.is_space && !info.is_minus && !info.is_plus;
        end
        PH_SIGNED: begin
          active    = 1'b1;
          begin_num = 1'b1;
        end
        PH_ZERO: begin
          active     = 1'b1;
          digit_path = !info.is_x;
          if (cur_base == BaseAuto) begin
            base_eff = BaseOct;
          end
        end
        PH_PREFIX: begin
          active     = 1'b1;
          base_eff   = BaseHex;
          digit_path = (info.digit < BaseHex);
          prefix_end = !(info.digit < BaseHex);
        end
        PH_DIGITS: begin
          active     = 1'b1;
          digit_path = 1'b1;
        end
        default: begin
          active = 1'b0;
        end
      endcase
    end
    zero_start = begin_num && info.is_zero && (cur_base == BaseAuto || cur_base == BaseHex);
    if (begin_num && !zero_start) begin
      digit_path = 1'b1;
      if (cur_base == BaseAuto) begin
        base_eff = BaseDec;
      end
    end
  end

  assign digit_take = digit_path && (info.digit < base_eff);
  assign emit       = (digit_path && !digit_take) || prefix_end;

  // Range limit for the current sign and mode.
  always_comb begin
    if (signed_mode) begin
      lim = cur_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      lim = '1;
    end
  end

  // One multiply-add by the radix, checked against the limit at full width.
  assign prod = 70'(cur_acc) * 70'(base_eff);
  assign sum  = 71'(prod) + 71'(info.digit);
  assign over = sum > 71'(lim);

  // Next state.
  always_comb begin
    phase_next = cur_phase;
    acc_next   = cur_acc;
    neg_next   = cur_neg;
    base_next  = cur_base;
    ovf_next   = cur_ovf;
    dseen_next = cur_dseen;
    pos_next   = cur_pos;
    if (bad_base) begin
      phase_next = PH_DONE;
      base_next  = BaseAuto;
    end else begin
      if (cur_phase == PH_SPACE && info.is_minus) begin
        neg_next   = 1'b1;
        phase_next = PH_SIGNED;
      end else if (cur_phase == PH_SPACE && info.is_plus) begin
        phase_next = PH_SIGNED;
      end
      if (cur_phase == PH_ZERO && info.is_x) begin
        phase_next = PH_PREFIX;
      end
      if (zero_start) begin
        acc_next   = '0;
        dseen_next = 1'b1;
        phase_next = PH_ZERO;
      end
      if (digit_path || prefix_end) begin
        base_next = base_eff;
      end
      if (digit_take) begin
        dseen_next = 1'b1;
        phase_next = PH_DIGITS;
        if (cur_ovf || over) begin
          ovf_next = 1'b1;
        end else begin
          acc_next = sum[63:0];
        end
      end
      if (emit) begin
        phase_next = PH_DONE;
      end
      if (active && cur_pos != CountMax) begin
        pos_next = cur_pos + 1'b1;
      end
    end
  end

  // Result word for a number that ends on this byte.
  always_comb begin
    res_valid = bad_base || emit;
    res.value  = '0;
    res.count  = '0;
    res.status = ST_OK;
    if (bad_base) begin
      res.status = ST_BAD_BASE;
    end else if (!cur_dseen) begin
      res.status = ST_NO_DIGITS;
    end else begin
      if (prefix_end) begin
        res.count = (cur_pos == CountMax) ? CountMax : cur_pos - 1'b1;
      end else begin
        res.count = cur_pos;
      end
      if (cur_ovf) begin
        res.value  = lim;
        res.status = ST_OVERFLOW;
      end else begin
        res.value = cur_neg ? (64'd0 - cur_acc) : cur_acc;
      end
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      acc   <= '0;
      neg   <= 1'b0;
      base  <= BaseAuto;
      ovf   <= 1'b0;
      dseen <= 1'b0;
      pos   <= '0;
    end else if (step_en) begin
      phase <= phase_next;
      acc   <= acc_next;
      neg   <= neg_next;
      base  <= base_next;
      ovf   <= ovf_next;
      dseen <= dseen_next;
      pos   <= pos_next;
    end
  end

endmodule

### rtl/text_to_integer_parser.sv
// Streaming text-to-integer parser: one text byte per word in, one result word per number.
// Bytes pass the input register, the combinational radix multiply-add and limit compare,
// and the result register; one byte per cycle unless a full result word is stalled.
// Reset (rst, synchronous): parser idle until a first byte, base 10, signed limits, both
// pipeline registers empty.
`timescale 1ns / 1ps

module text_to_integer_parser
  import ttoi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port.
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [BaseWidth-1:0]  cfg_data,
  // Byte input channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            text_byte,
  input  logic                  first_byte,
  // Result output channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [63:0]           result_value,
  output logic [CountWidth-1:0] consumed_count,
  output logic [1:0]            parse_status
);

  logic [BaseWidth-1:0] number_base;
  logic                 signed_mode;

  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       in_q_first;

  logic       advance;
  logic       step_en;
  char_info_t info;
  logic       res_valid;
  result_t    res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BaseDec;
      signed_mode <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CfgNumberBase: number_base <= cfg_data;
        CfgSignedMode: signed_mode <= cfg_data[0];
        default:       number_base <= number_base;
      endcase
    end
  end

  // The parse stage moves whenever the result register can take a word.
  assign advance  = !out_valid || !out_stall;
  assign step_en  = in_q_valid && advance;
  assign in_stall = in_q_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_byte  <= text_byte;
      in_q_first <= first_byte;
    end
  end

  ttoi_classify u_classify (
    .text_byte (in_q_byte),
    .info      (info)
  );

  ttoi_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step_en     (step_en),
    .first       (in_q_first),
    .info        (info),
    .number_base (number_base),
    .signed_mode (signed_mode),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step_en && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res_valid) begin
      result_value   <= res.value;
      consumed_count <= res.count;
      parse_status   <= res.status;
    end
  end

  // A stalled input only ever comes from a full, stalled result register.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the result register could drain");

  // Words with no value carry neither a value nor a count.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (parse_status == ST_BAD_BASE || parse_status == ST_NO_DIGITS))
      |-> (result_value == 64'd0 && consumed_count == '0))
    else $error("empty result word carries a value or count");

  // A result word leaves only when it is taken.
  assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> !$past(out_stall))
    else $error("result word dropped while stalled");

endmodule
